FILE: src/mcas_pkg.sv
// shared constants and types for the assignment solver
package mcas_pkg;

	localparam int MaxRows = 16;
	localparam int MaxCols = 16;
	localparam int IdxW = 5;
	localparam int CostW = 16;
	localparam int PotW = 32;
	localparam int TotW = 20;
	localparam int AddrW = 8;
	localparam int NumCols = MaxCols + 1;
	localparam int NumRows = MaxRows + 1;
	localparam logic signed [PotW-1:0] SlackInf = 32'sd1000000000;

	localparam logic CFG_ROW_COUNT = 1'b0;
	localparam logic CFG_COL_COUNT = 1'b1;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_ROW_INIT = 9'b000000010,
		ST_STEP     = 9'b000000100,
		ST_SCAN_RD  = 9'b000001000,
		ST_SCAN_EV  = 9'b000010000,
		ST_UPD      = 9'b000100000,
		ST_AUG      = 9'b001000000,
		ST_ASSIGN   = 9'b010000000,
		ST_EMIT     = 9'b100000000
	} state_t;

	typedef logic signed [PotW-1:0] pot_t;
	typedef logic [IdxW-1:0] idx_t;

endpackage

FILE: src/min_cost_assignment_solver.sv
// top level of the minimum-cost assignment solver
//
// channel  dir  fields
// s_axis   in   tdata: row_index[3:0] col_index[7:4] cost[23:8]; tlast: last_entry
// m_axis   out  tdata: out_row[3:0] assigned_col[7:4] total_cost[27:8]; tuser: status;
//               tlast: last_result
// cfg      in   cfg_we, cfg_index (0 row_count, 1 col_count), cfg_data
//
// entries load one per cycle into the cost ram while the solver is idle;
// the solve then runs, for each row and path step, a scan (ram read then
// evaluate for each column) and an update sweep over the columns, then
// inverts the owner table and emits one result beat per row (one error beat if rows exceed columns).
// arst_n clears all control state; the cost ram keeps no reset.
// input is held off from the last entry until the final result is loaded.
module min_cost_assignment_solver
	import mcas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // row_index, col_index, cost
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_row, assigned_col, total_cost, zero pad
	output logic        m_tuser,  // status
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	state_t state_q;
	logic [4:0] row_cnt_q, col_cnt_q;
	idx_t n_q, m_q;
	idx_t i_q, j_q, cur_q, guard_q, r_q, next_q, k_q;
	pot_t delta_q;
	logic found_q, err_q;

	pot_t u_q [NumRows];
	pot_t v_q [NumCols];
	pot_t ms_q [NumCols];
	idx_t owner_q [NumCols];
	idx_t link_q [NumCols];
	logic [NumCols-1:0] vis_q;
	idx_t assign_q [NumRows];

	logic m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [31:0] m_tdata_q;

	logic s_acc;
	logic [CostW-1:0] cost_rd;
	logic [AddrW-1:0] raddr;
	idx_t n_c, m_c, rm1, jm1, prev_c, ow_j, col_c;
	pot_t red_c, slack_c;
	logic load_c, last_c;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid & s_tready;

	// clamp counts into range
	always_comb begin
		n_c = (row_cnt_q == 5'd0) ? 5'd1 : (row_cnt_q > 5'(MaxRows)) ? 5'(MaxRows) : row_cnt_q;
		m_c = (col_cnt_q == 5'd0) ? 5'd1 : (col_cnt_q > 5'(MaxCols)) ? 5'(MaxCols) : col_cnt_q;
	end

	// cost ram read address
	assign rm1 = r_q - 5'd1;
	assign jm1 = j_q - 5'd1;
	assign raddr = {rm1[3:0], jm1[3:0]};

	mcas_ram #(.Width(CostW), .Depth(MaxRows * MaxCols)) u_cost_ram (
		.clk   (clk),
		.we    (s_acc),
		.waddr ({s_tdata[3:0], s_tdata[7:4]}),
		.wdata (s_tdata[23:8]),
		.raddr (raddr),
		.rdata (cost_rd)
	);

	// reduced cost and running slack for the scanned column
	always_comb begin
		red_c = $signed({16'd0, cost_rd}) - u_q[r_q] - v_q[j_q];
		slack_c = (red_c < ms_q[j_q]) ? red_c : ms_q[j_q];
		prev_c = link_q[cur_q];
		ow_j = owner_q[j_q];
		col_c = assign_q[k_q + 5'd1];
		load_c = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
		last_c = err_q || (k_q + 5'd1 == n_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= 5'd16;
			col_cnt_q <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_COUNT: row_cnt_q <= cfg_data;
				CFG_COL_COUNT: col_cnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// solver sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0; m_q <= '0; i_q <= '0; j_q <= '0; cur_q <= '0;
			guard_q <= '0; r_q <= 5'd1; next_q <= '0; k_q <= '0;
			found_q <= 1'b0; err_q <= 1'b0; delta_q <= '0; vis_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc && s_tlast) begin
						n_q <= n_c;
						m_q <= m_c;
						k_q <= '0;
						if (n_c > m_c) begin
							err_q <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							err_q <= 1'b0;
							i_q <= 5'd1;
							for (int c = 0; c < NumCols; c++) begin
								v_q[c] <= '0;
								owner_q[c] <= '0;
								link_q[c] <= '0;
							end
							for (int c = 0; c < NumRows; c++) u_q[c] <= '0;
							state_q <= ST_ROW_INIT;
						end
					end
				end
				ST_ROW_INIT: begin
					for (int c = 0; c < NumCols; c++) ms_q[c] <= SlackInf;
					vis_q <= '0;
					owner_q[0] <= i_q;
					cur_q <= '0;
					guard_q <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (owner_q[cur_q] != 5'd0 && guard_q <= m_q) begin
						r_q <= owner_q[cur_q];
						vis_q[cur_q] <= 1'b1;
						guard_q <= guard_q + 5'd1;
						delta_q <= SlackInf;
						found_q <= 1'b0;
						j_q <= 5'd1;
						state_q <= ST_SCAN_RD;
					end else begin
						guard_q <= '0;
						state_q <= ST_AUG;
					end
				end
				ST_SCAN_RD: state_q <= ST_SCAN_EV;
				ST_SCAN_EV: begin
					if (!vis_q[j_q]) begin
						if (red_c < ms_q[j_q]) begin
							ms_q[j_q] <= red_c;
							link_q[j_q] <= cur_q;
						end
						if (slack_c < delta_q) begin
							delta_q <= slack_c;
							next_q <= j_q;
							found_q <= 1'b1;
						end
					end
					if (j_q == m_q) begin
						j_q <= '0;
						if (found_q || (!vis_q[j_q] && slack_c < delta_q)) begin
							state_q <= ST_UPD;
						end else begin
							guard_q <= '0;
							state_q <= ST_AUG;
						end
					end else begin
						j_q <= j_q + 5'd1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_UPD: begin
					if (vis_q[j_q]) begin
						u_q[ow_j] <= u_q[ow_j] + delta_q;
						v_q[j_q] <= v_q[j_q] - delta_q;
					end else begin
						ms_q[j_q] <= ms_q[j_q] - delta_q;
					end
					if (j_q == m_q) begin
						cur_q <= next_q;
						state_q <= ST_STEP;
					end else begin
						j_q <= j_q + 5'd1;
					end
				end
				ST_AUG: begin
					if (cur_q != 5'd0 && guard_q <= m_q) begin
						owner_q[cur_q] <= owner_q[prev_c];
						cur_q <= prev_c;
						guard_q <= guard_q + 5'd1;
					end else if (i_q == n_q) begin
						for (int c = 0; c < NumRows; c++) assign_q[c] <= '0;
						k_q <= 5'd1;
						state_q <= ST_ASSIGN;
					end else begin
						i_q <= i_q + 5'd1;
						state_q <= ST_ROW_INIT;
					end
				end
				ST_ASSIGN: begin
					// invert the column owner table
					if (owner_q[k_q] <= n_q) assign_q[owner_q[k_q]] <= k_q;
					if (k_q == m_q) begin
						k_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				ST_EMIT: begin
					if (load_c) begin
						k_q <= k_q + 5'd1;
						if (last_c) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_c) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (load_c) begin
			m_tuser_q <= err_q;
			m_tlast_q <= last_c;
			if (err_q) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= {4'd0, TotW'(-v_q[0]),
					(col_c != 5'd0) ? 4'(col_c - 5'd1) : 4'd0, k_q[3:0]};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

	// an error beat is always the final beat
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("error beat without last");

	// the last entry closes the input until results are loaded
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input open after last entry");

	// back-pointer walk stays inside the used columns
	a_aug_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AUG |-> cur_q <= m_q)
		else $error("augment column out of range");

endmodule

FILE: src/mcas_ram.sv
// generic single-write single-read ram with registered read
module mcas_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: test/testbench.sv
// self-checking testbench for the minimum-cost assignment solver
module testbench;
	import mcas_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic {STATUS_SOLVED = 1'b0, STATUS_TOO_MANY_ROWS = 1'b1} status_e;
	typedef enum logic [1:0] {OP_CFG, OP_ENTRY} op_e;

	typedef struct {
		logic [3:0]  row;
		logic [3:0]  col;
		logic [19:0] total;
		logic        status;
		logic        last;
	} assign_beat_t;

	typedef struct {
		op_e         op;
		int          a;      // entry row or register index
		int          b;      // entry column or register value
		logic [15:0] cost;
		logic        last;
		bit          typed;  // expectation given in the row
		logic [3:0]  e_col;
		logic [19:0] e_total;
		logic        e_status;
	} dir_row_t;

	localparam longint Inf = 64'd1000000000;
	localparam int SettleCycles = 20;
	localparam int HoldCycles = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;

	assign_beat_t expected_assignments[$];
	logic [15:0]  cost_mem [256];
	bit           cell_written [256];
	logic [4:0]   rows_reg = 5'd16;
	logic [4:0]   cols_reg = 5'd16;
	int           errors = 0;
	int           entries_sent = 0;
	int           solves = 0;
	int           refusals = 0;
	int           beats_seen = 0;
	event         hold_go;
	bit           hold_on = 0;
	bit           send_burst = 0;

	min_cost_assignment_solver i_dut (.*);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int eff_count(logic [4:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	// hungarian solve on the stored matrix, pushes one beat per row
	function automatic void predict_assignment(int n, int m);
		longint rp [17];
		longint cp [17];
		longint slack [17];
		int owner [17];
		int link [17];
		bit vis [17];
		int assign_of [17];
		int cur, guard, r, nxt, prev;
		longint delta, red;
		bit found;
		logic [19:0] total;
		assign_beat_t b;
		for (int j = 0; j < 17; j++) begin
			rp[j] = 0; cp[j] = 0; owner[j] = 0; link[j] = 0; assign_of[j] = 0;
		end
		for (int i = 1; i <= n; i++) begin
			cur = 0;
			guard = 0;
			for (int j = 0; j <= m; j++) begin
				slack[j] = Inf;
				vis[j] = 0;
			end
			owner[0] = i;
			while (owner[cur] != 0 && guard <= m) begin
				r = owner[cur];
				delta = Inf;
				nxt = 0;
				found = 0;
				guard++;
				vis[cur] = 1;
				for (int j = 1; j <= m; j++) begin
					if (!vis[j]) begin
						red = longint'(cost_mem[(r - 1) * 16 + j - 1]) - rp[r] - cp[j];
						if (red < slack[j]) begin
							slack[j] = red;
							link[j] = cur;
						end
						if (slack[j] < delta) begin
							delta = slack[j];
							nxt = j;
							found = 1;
						end
					end
				end
				if (!found) break;
				for (int j = 0; j <= m; j++) begin
					if (vis[j]) begin
						rp[owner[j]] += delta;
						cp[j] -= delta;
					end else begin
						slack[j] -= delta;
					end
				end
				cur = nxt;
			end
			guard = 0;
			while (cur != 0 && guard <= m) begin
				prev = link[cur];
				owner[cur] = owner[prev];
				cur = prev;
				guard++;
			end
		end
		for (int k = 1; k <= m; k++)
			if (owner[k] <= n) assign_of[owner[k]] = k;
		total = 20'((-cp[0]) & 64'hFFFFF);
		for (int k = 0; k < n; k++) begin
			b.row = 4'(k);
			b.col = assign_of[k + 1] ? 4'(assign_of[k + 1] - 1) : 4'd0;
			b.total = total;
			b.status = STATUS_SOLVED;
			b.last = (k + 1 == n);
			expected_assignments.push_back(b);
		end
	endfunction

	// store the entry and, on a last mark, work out the beats
	function automatic void predict_entry(int r, int c, logic [15:0] cost, logic last);
		int n, m;
		assign_beat_t b;
		cost_mem[r * 16 + c] = cost;
		cell_written[r * 16 + c] = 1;
		if (!last) return;
		n = eff_count(rows_reg, MaxRows);
		m = eff_count(cols_reg, MaxCols);
		if (n > m) begin
			b = '{row: 0, col: 0, total: 0, status: STATUS_TOO_MANY_ROWS, last: 1};
			expected_assignments.push_back(b);
			refusals++;
		end else begin
			predict_assignment(n, m);
			solves++;
		end
	endfunction

	// drive one entry beat and wait for it to be taken
	task automatic send_entry(int r, int c, logic [15:0] cost, logic last, bit typed = 0,
			assign_beat_t tb = '{default: 0});
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cost, 4'(c), 4'(r)};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		entries_sent++;
		if (typed) begin
			cost_mem[r * 16 + c] = cost;
			cell_written[r * 16 + c] = 1;
			expected_assignments.push_back(tb);
		end else begin
			predict_entry(r, c, cost, last);
		end
	endtask

	// register write, only once the block has gone quiet
	task automatic write_reg(logic idx, logic [4:0] val);
		s_tvalid <= 1'b0;
		while (expected_assignments.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_ROW_COUNT) rows_reg = val;
		else cols_reg = val;
	endtask

	// long receiver hold-off, counted here
	initial begin
		forever begin
			@(hold_go);
			hold_on = 1;
			repeat (HoldCycles) @(posedge clk);
			hold_on = 0;
		end
	end

	// result side: random stalls, ready dropped during a hold-off
	initial begin
		int gap;
		assign_beat_t e;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (gap > 0 && !hold_on) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= !hold_on;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) begin
				m_tready <= !hold_on;
				@(posedge clk);
			end
			beats_seen++;
			if (expected_assignments.size() == 0) begin
				$display("%0t: unexpected beat tdata=%h tuser=%b tlast=%b", $time, m_tdata,
					m_tuser, m_tlast);
				errors++;
			end else begin
				e = expected_assignments.pop_front();
				if (m_tdata[3:0] !== e.row) begin
					$display("%0t: out_row exp %0d got %0d", $time, e.row, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[7:4] !== e.col) begin
					$display("%0t: assigned_col exp %0d got %0d", $time, e.col, m_tdata[7:4]);
					errors++;
				end
				if (m_tdata[27:8] !== e.total) begin
					$display("%0t: total_cost exp %0d got %0d", $time, e.total, m_tdata[27:8]);
					errors++;
				end
				if (m_tuser !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, m_tuser);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: last_result exp %0d got %0d", $time, e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t dir_tab [17];
		assign_beat_t tb;
		int n, m, rnd_items, frame, sel, noise;
		bit small_costs;
		logic [15:0] cv;
		dir_tab = '{
			'{OP_CFG, 0, 1, 0, 0, 0, 0, 0, 0},
			'{OP_CFG, 1, 1, 0, 0, 0, 0, 0, 0},
			'{OP_ENTRY, 0, 0, 16'hFFFF, 1, 1, 0, 20'd65535, STATUS_SOLVED},
			'{OP_ENTRY, 0, 0, 16'h0000, 1, 1, 0, 20'd0, STATUS_SOLVED},
			// more rows than columns
			'{OP_CFG, 0, 2, 0, 0, 0, 0, 0, 0},
			'{OP_ENTRY, 5, 3, 16'd7, 1, 1, 0, 20'd0, STATUS_TOO_MANY_ROWS},
			// zero counts behave as one
			'{OP_CFG, 0, 0, 0, 0, 0, 0, 0, 0},
			'{OP_CFG, 1, 0, 0, 0, 0, 0, 0, 0},
			'{OP_ENTRY, 0, 0, 16'd123, 1, 1, 0, 20'd123, STATUS_SOLVED},
			// crossed 2x2, left to the predictor
			'{OP_CFG, 0, 2, 0, 0, 0, 0, 0, 0},
			'{OP_CFG, 1, 2, 0, 0, 0, 0, 0, 0},
			'{OP_ENTRY, 0, 0, 16'd10, 0, 0, 0, 0, 0},
			'{OP_ENTRY, 0, 1, 16'd1, 0, 0, 0, 0, 0},
			'{OP_ENTRY, 1, 0, 16'd1, 0, 0, 0, 0, 0},
			'{OP_ENTRY, 1, 1, 16'd10, 1, 0, 0, 0, 0},
			// oversized row count clamps to the maximum, still too many rows
			'{OP_CFG, 0, 31, 0, 0, 0, 0, 0, 0},
			'{OP_ENTRY, 15, 15, 16'hFFFF, 1, 1, 0, 20'd0, STATUS_TOO_MANY_ROWS}
		};
		foreach (cell_written[k]) cell_written[k] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (dir_tab[k]) begin
			if (dir_tab[k].op == OP_CFG) begin
				write_reg(dir_tab[k].a[0], 5'(dir_tab[k].b));
			end else begin
				tb = '{row: 0, col: dir_tab[k].e_col, total: dir_tab[k].e_total,
					status: dir_tab[k].e_status, last: 1};
				send_entry(dir_tab[k].a, dir_tab[k].b, dir_tab[k].cost, dir_tab[k].last,
					dir_tab[k].typed, tb);
			end
		end

		// random frames; the frame after the hold-off keeps its sizes so that
		// its entries are offered while the held results block the input
		rnd_items = 0;
		frame = 0;
		while (rnd_items < 165 || frame < 8) begin
			sel = $urandom_range(0, 9);
			if (frame != 6) begin
				if (frame == 3) begin
					write_reg(CFG_ROW_COUNT, 5'd8);
					write_reg(CFG_COL_COUNT, 5'd8);
				end else if (sel == 0) begin
					n = $urandom_range(2, 31);
					write_reg(CFG_ROW_COUNT, 5'(n));
					write_reg(CFG_COL_COUNT, 5'($urandom_range(1, (n > 16 ? 16 : n) - 1)));
				end else if (sel == 1) begin
					write_reg(CFG_ROW_COUNT, $urandom_range(0, 1) ? 5'd0 : 5'd1);
					write_reg(CFG_COL_COUNT, 5'($urandom_range(17, 31)));
				end else begin
					n = $urandom_range(1, 4);
					write_reg(CFG_ROW_COUNT, 5'(n));
					write_reg(CFG_COL_COUNT, 5'($urandom_range(n, n + $urandom_range(0, 3))));
				end
			end
			n = eff_count(rows_reg, MaxRows);
			m = eff_count(cols_reg, MaxCols);
			small_costs = $urandom_range(0, 1);
			send_burst = (frame == 6) || ($urandom_range(0, 3) == 0);
			// fill every cell the solve will read
			if (n <= m) begin
				for (int r = 0; r < n; r++)
					for (int c = 0; c < m; c++)
						if (!cell_written[r * 16 + c]) begin
							cv = small_costs ? 16'($urandom_range(0, 3)) : 16'($urandom);
							send_entry(r, c, cv, 0);
							rnd_items++;
						end
			end
			// overwrites anywhere, then the closing entry
			noise = $urandom_range(0, 5);
			for (int k = 0; k <= noise; k++) begin
				cv = small_costs ? 16'($urandom_range(0, 3)) : 16'($urandom);
				if (k < noise) begin
					send_entry($urandom_range(0, 15), $urandom_range(0, 15), cv, 0);
				end else begin
					if (frame == 5) -> hold_go;
					send_entry($urandom_range(0, n - 1), $urandom_range(0, m - 1), cv, 1);
				end
				rnd_items++;
			end
			frame++;
		end
		s_tvalid <= 1'b0;

		// drain
		while (expected_assignments.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		$display("summary: %0d entries, %0d solves, %0d refusals, %0d result beats",
			entries_sent, solves, refusals, beats_seen);
		$display("summary: matrix sizes 1x1 to 8x8 and 1x16, clamped and too-many-rows settings");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// overall time limit
	initial begin
		#4ms;
		$display("timeout with %0d beats outstanding", expected_assignments.size());
		$display("testbench: done, errors");
		$finish;
	end

endmodule
